// ----- hdl/csi_pkg.sv -----
`timescale 1ns / 1ps

package csi_pkg;

   // Fixed field widths.
   localparam int SAMPLE_W    = 24;
   localparam int FRAC_W      = 16;
   localparam int POS_W       = 32;
   localparam int FRAME_W     = 18;
   localparam int FRAMES_W    = 19;
   localparam int CHANS_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 19;

   // Frame index width that covers the widest supported store.
   localparam int IDX_W = 21;

   // Rounding constant for the final shift by 17.
   localparam int ROUND_HALF = 65536;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS = 2'd1;

   // One classified operation waiting for the back end.
   typedef struct packed {
      logic                       is_read;
      logic                       is_empty;
      logic                       chan;
      logic [IDX_W-1:0]           idx;
      logic [IDX_W-1:0]           lenm1;
      logic [FRAC_W-1:0]          frac;
      logic signed [SAMPLE_W-1:0] wdata;
   } entry_type;

   // Queue status seen by front and back.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- hdl/csi_ram.sv -----
`timescale 1ns / 1ps

module csi_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port with registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/csi_queue.sv -----
`timescale 1ns / 1ps

module csi_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  csi_pkg::entry_type         push_entry,
   input  logic                       pop,
   output csi_pkg::entry_type         head,
   output csi_pkg::queue_status_type  status
);

   csi_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

// ----- hdl/csi_front.sv -----
`timescale 1ns / 1ps

module csi_front #(
   parameter int MAX_FRAMES   = 262144,
   parameter int MAX_CHANNELS = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   req_op,
   input  logic                                   req_channel,
   input  logic [csi_pkg::FRAME_W-1:0]            req_frame_index,
   input  logic signed [csi_pkg::SAMPLE_W-1:0]    req_sample_value,
   input  logic [csi_pkg::POS_W-1:0]              req_position,
   input  logic [csi_pkg::FRAMES_W-1:0]           frames_cfg,
   input  logic [csi_pkg::CHANS_W-1:0]            chans_cfg,
   input  csi_pkg::queue_status_type              q_status,
   output logic                                   busy,
   output logic                                   push,
   output csi_pkg::entry_type                     push_entry
);

   localparam int FW = $clog2(MAX_FRAMES);
   localparam int LW = FW + 1;
   localparam int PW = csi_pkg::POS_W + FW;
   localparam logic [csi_pkg::POS_W-1:0] ONE_Q31 = 32'h8000_0000;

   logic                                vld_ff, vld_in;
   logic                                op_ff;
   logic                                chan_ff;
   logic [csi_pkg::FRAME_W-1:0]         frame_ff;
   logic signed [csi_pkg::SAMPLE_W-1:0] sample_ff;
   logic [csi_pkg::POS_W-1:0]           pos_ff;

   logic                       accept;
   logic [LW-1:0]              len;
   logic [FW-1:0]              lenm1;
   logic [csi_pkg::POS_W-1:0]  pos_c;
   logic [PW-1:0]              prod;
   logic                       read_chan;
   logic                       write_ok;

   assign busy   = vld_ff && q_status.full;
   assign accept = start && !busy;

   // Holding stage: an item stays until the queue takes it.
   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (!q_status.full) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         op_ff     <= req_op;
         chan_ff   <= req_channel;
         frame_ff  <= req_frame_index;
         sample_ff <= req_sample_value;
         pos_ff    <= req_position;
      end
   end

   // Clamp length, channel and position, then scale the position.
   always_comb begin
      if (32'(frames_cfg) > 32'(MAX_FRAMES)) begin
         len = LW'(MAX_FRAMES);
      end else begin
         len = LW'(frames_cfg);
      end
      lenm1     = FW'(len - LW'(1));
      pos_c     = (pos_ff > ONE_Q31) ? ONE_Q31 : pos_ff;
      prod      = PW'(pos_c) * PW'(lenm1);
      read_chan = chan_ff && (MAX_CHANNELS > 1) && (chans_cfg >= 2'd2);
      write_ok  = (32'(frame_ff) < 32'(MAX_FRAMES)) && (!chan_ff || (MAX_CHANNELS > 1));
   end

   // Classify the held item into a queue entry.
   always_comb begin
      push_entry          = '0;
      push_entry.is_read  = op_ff;
      push_entry.wdata    = sample_ff;
      if (op_ff) begin
         push_entry.is_empty = (len == '0);
         push_entry.chan     = read_chan;
         push_entry.idx      = csi_pkg::IDX_W'(prod[31 +: FW]);
         push_entry.lenm1    = csi_pkg::IDX_W'(lenm1);
         push_entry.frac     = prod[30:15];
      end else begin
         push_entry.chan     = chan_ff;
         push_entry.idx      = csi_pkg::IDX_W'(frame_ff);
      end
   end

   // Out-of-range writes are dropped here.
   assign push = vld_ff && !q_status.full && (op_ff || write_ok);

endmodule

// ----- hdl/csi_back.sv -----
`timescale 1ns / 1ps

module csi_back #(
   parameter int MAX_FRAMES   = 262144,
   parameter int MAX_CHANNELS = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  csi_pkg::entry_type                  head,
   input  csi_pkg::queue_status_type           q_status,
   output logic                                pop,
   output logic                                rsp_strobe,
   output logic signed [csi_pkg::SAMPLE_W-1:0] rsp_value
);

   localparam int FW = $clog2(MAX_FRAMES);
   localparam int AW = $clog2(MAX_CHANNELS * MAX_FRAMES);
   localparam int SW = csi_pkg::SAMPLE_W;
   localparam int IW = 30;
   localparam int PW = IW + csi_pkg::FRAC_W + 1;
   localparam int XW = PW + 2;
   localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_COEF, S_MUL1, S_MUL2, S_MUL3
   } state_type;

   state_type                   state_ff, state_in;
   csi_pkg::entry_type          cur_ff, cur_in;
   logic [2:0]                  cnt_ff, cnt_in;
   logic signed [SW-1:0]        x_ff [4];
   logic signed [IW-1:0]        a2_ff, b2_ff, c2_ff, t_ff;
   logic signed [IW-1:0]        a2_in, b2_in, c2_in, t_in;
   logic                        strobe_ff, strobe_in;
   logic signed [SW-1:0]        value_ff, value_in;

   logic                        ram_we;
   logic [AW-1:0]               ram_addr;
   logic [SW-1:0]               ram_rdata;
   logic [AW-1:0]               base;
   logic [FW+1:0]               nb;
   logic [FW-1:0]               nb_c;
   logic [FW-1:0]               idx;
   logic [FW-1:0]               lenm1;
   logic signed [IW-1:0]        xe0, xe1, xe2, xe3;
   logic signed [IW-1:0]        mul_a, add_c;
   logic signed [PW-1:0]        mul_p, mul_sh;
   logic signed [XW-1:0]        s_sum, r_full;

   csi_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_CHANNELS * MAX_FRAMES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (head.wdata),
      .rdata (ram_rdata)
   );

   // Neighbor index for the current fetch step, clamped to the loaded range.
   always_comb begin
      idx   = cur_ff.idx[FW-1:0];
      lenm1 = cur_ff.lenm1[FW-1:0];
      nb    = {2'b00, idx} + {{FW{1'b0}}, cnt_ff[1:0]} - (FW + 2)'(1);
      if (nb[FW+1]) begin
         nb_c = '0;
      end else if (nb[FW:0] > {1'b0, lenm1}) begin
         nb_c = lenm1;
      end else begin
         nb_c = nb[FW-1:0];
      end
   end

   // Store address: writes come straight from the queue head.
   always_comb begin
      if (state_ff == S_IDLE) begin
         base     = head.chan ? AW'(MAX_FRAMES) : '0;
         ram_addr = base + AW'(head.idx[FW-1:0]);
      end else begin
         base     = cur_ff.chan ? AW'(MAX_FRAMES) : '0;
         ram_addr = base + AW'(nb_c);
      end
   end

   // Shared multiplier for the three Horner steps.
   always_comb begin
      xe0    = IW'(x_ff[0]);
      xe1    = IW'(x_ff[1]);
      xe2    = IW'(x_ff[2]);
      xe3    = IW'(x_ff[3]);
      a2_in  = -xe0 + (xe1 <<< 1) + xe1 - (xe2 <<< 1) - xe2 + xe3;
      b2_in  = (xe0 <<< 1) - (xe1 <<< 2) - xe1 + (xe2 <<< 2) - xe3;
      c2_in  = xe2 - xe0;
      mul_a  = (state_ff == S_MUL1) ? a2_ff : t_ff;
      add_c  = (state_ff == S_MUL1) ? b2_ff : c2_ff;
      mul_p  = PW'(mul_a) * PW'($signed({1'b0, cur_ff.frac}));
      mul_sh = mul_p >>> csi_pkg::FRAC_W;
      t_in   = IW'(mul_sh + PW'(add_c));
      s_sum  = XW'(mul_p) + (XW'(x_ff[1]) <<< 17) + XW'(csi_pkg::ROUND_HALF);
      r_full = s_sum >>> 17;
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      value_in  = value_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (!head.is_read) begin
                  ram_we = 1'b1;
               end else if (head.is_empty) begin
                  strobe_in = 1'b1;
                  value_in  = '0;
               end else begin
                  cur_in   = head;
                  cnt_in   = 3'd0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = S_COEF;
            end
         end
         S_COEF: begin
            state_in = S_MUL1;
         end
         S_MUL1: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            state_in = S_MUL3;
         end
         S_MUL3: begin
            strobe_in = 1'b1;
            if (r_full > SAT_HI) begin
               value_in = SAT_HI[SW-1:0];
            end else if (r_full < SAT_LO) begin
               value_in = SAT_LO[SW-1:0];
            end else begin
               value_in = r_full[SW-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      cur_ff   <= cur_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
      if (state_ff == S_FETCH && cnt_ff != 3'd0) begin
         x_ff[cnt_ff[1:0] - 2'd1] <= ram_rdata;
      end
      if (state_ff == S_COEF) begin
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         c2_ff <= c2_in;
      end
      if (state_ff == S_MUL1 || state_ff == S_MUL2) begin
         t_ff <= t_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_value  = value_ff;

endmodule

// ----- hdl/cubic_sample_interpolator_unit.sv -----
`timescale 1ns / 1ps

// Channel   Transfer                         Payload
// request   start high while busy low        req_op, req_channel, req_frame_index,
//                                            req_sample_value, req_position
// response  rsp_strobe high for one cycle    rsp_value
// config    csr_write_enable high            csr_index, csr_data
//
// The back end handles one read at a time: four fetches on the single store
// port, then a coefficient step and three Horner steps on one shared multiplier.
// A write is done from the idle state with one store write, and reads of an
// empty store answer zero without any fetch. Reset is synchronous and clears
// control state only. The two-entry queue lets the front keep accepting while
// the back end works; busy rises when the queue and the front holding stage
// are both full.

module cubic_sample_interpolator_unit #(
   parameter int MAX_FRAMES   = 262144,
   parameter int MAX_CHANNELS = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_op,
   input  logic                                   req_channel,
   input  logic [csi_pkg::FRAME_W-1:0]            req_frame_index,
   input  logic signed [csi_pkg::SAMPLE_W-1:0]    req_sample_value,
   input  logic [csi_pkg::POS_W-1:0]              req_position,
   output logic                                   rsp_strobe,
   output logic signed [csi_pkg::SAMPLE_W-1:0]    rsp_value,
   input  logic                                   csr_write_enable,
   input  logic [csi_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [csi_pkg::CSR_DATA_W-1:0]         csr_data
);

   logic [csi_pkg::FRAMES_W-1:0] frames_ff;
   logic [csi_pkg::CHANS_W-1:0]  chans_ff;

   logic                       push;
   logic                       pop;
   csi_pkg::entry_type         push_entry;
   csi_pkg::entry_type         head;
   csi_pkg::queue_status_type  q_status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
         chans_ff  <= csi_pkg::CHANS_W'(1);
      end else if (csr_write_enable) begin
         if (csr_index == csi_pkg::CSR_FRAMES) begin
            frames_ff <= csr_data;
         end else if (csr_index == csi_pkg::CSR_CHANNELS) begin
            chans_ff <= csr_data[csi_pkg::CHANS_W-1:0];
         end
      end
   end

   csi_front #(
      .MAX_FRAMES   (MAX_FRAMES),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_op           (req_op),
      .req_channel      (req_channel),
      .req_frame_index  (req_frame_index),
      .req_sample_value (req_sample_value),
      .req_position     (req_position),
      .frames_cfg       (frames_ff),
      .chans_cfg        (chans_ff),
      .q_status         (q_status),
      .busy             (busy),
      .push             (push),
      .push_entry       (push_entry)
   );

   csi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   csi_back #(
      .MAX_FRAMES   (MAX_FRAMES),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value)
   );

endmodule

// ----- hdl/csi_checker.sv -----
`timescale 1ns / 1ps

module csi_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // Nothing is in flight right after reset.
   assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("busy or response right after reset");

   // Handshake outputs are always driven to known levels out of reset.
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown(busy) && !$isunknown(rsp_strobe))
      else $error("busy or rsp_strobe unknown");

   // busy only rises after a request transfer.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without a request transfer");

endmodule

bind cubic_sample_interpolator_unit csi_checker u_csi_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
